// File: design/lems_pkg.sv
// Shared types and constants for the light effect macro sequencer.
// Holds the request codes, register indexes, table entry layout and sequencer states.
// No dependencies.
package lems_pkg;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_START = 2'd2
  } req_type_t;

  // Configuration port.
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_ADDR_W-1:0] CFG_TEMPLATE_LENGTH = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FADE_STEPS      = 1'b1;

  localparam logic [2:0] MODE_REVERSE_WAVE = 3'd4;

  // Iterations of the shared divider for each kind of quotient.
  localparam logic [4:0] DIV_WAVE_STEPS  = 5'd17;
  localparam logic [4:0] DIV_RATIO_STEPS = 5'd8;

  localparam logic [7:0] RATIO_FULL = 8'hFF;

  // One macro table word, high field first.
  typedef struct packed {
    logic [7:0] color;
    logic       has_color;
    logic [2:0] mode;
    logic [3:0] next;
    logic [7:0] repeats;
    logic [7:0] duration;
  } macro_entry_t;

  localparam int ENTRY_W = $bits(macro_entry_t);

  // The blank delay entry: one tick, no repeats, entry zero follows, no color change.
  localparam macro_entry_t PREQUEL_ENTRY = '{
    color: 8'd0, has_color: 1'b0, mode: 3'd0, next: 4'd0, repeats: 8'd0, duration: 8'd1
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_START_RD,
    S_START_LOAD,
    S_TICK_RD,
    S_TICK_CUR,
    S_TICK_NEW,
    S_WAVE_DIV,
    S_ADVANCE,
    S_RATIO_SETUP,
    S_RATIO_DIV,
    S_OUT
  } seq_state_t;

endpackage

// File: design/lems_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the macro table of the light effect macro sequencer.
// No dependencies.
module lems_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/light_effect_macro_sequencer.sv
// Light effect macro sequencer: walks a table of effect entries one tick at a time.
// Depends on lems_pkg and lems_ram (the macro table).
// Writes leave busy low. A start is busy until the wave step divide is done.
// A tick reads its entry, may run the 17-step serial divider for the wave step,
// advances, may run the 8-step divider pass for the dissolve ratio and then
// strobes result_valid. busy drops in the strobe cycle. Results cannot be held off.
// Reset is synchronous: state, counters, colors and result_valid clear, template_length returns to 256.
module light_effect_macro_sequencer #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  // Request channel.
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         req_type,
  input  logic [3:0]                         entry_index,
  input  logic [7:0]                         entry_duration,
  input  logic [7:0]                         entry_repeats,
  input  logic [3:0]                         entry_next,
  input  logic [2:0]                         entry_mode,
  input  logic                               entry_has_color,
  input  logic [7:0]                         entry_color_id,
  input  logic [7:0]                         start_delay,
  input  logic                               start_has_color,
  input  logic [7:0]                         start_color_id,
  // Configuration port.
  input  logic                               cfg_we,
  input  logic [lems_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lems_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // Result channel.
  output logic                               result_valid,
  output logic [2:0]                         mode,
  output logic [3:0]                         active_entry,
  output logic                               in_prequel,
  output logic [7:0]                         sample_index,
  output logic [7:0]                         current_color_id,
  output logic [7:0]                         previous_color_id,
  output logic [7:0]                         dissolve_ratio
);

  import lems_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0] DEPTH_W9 = 9'(TABLE_DEPTH);

  // Next indices wrap modulo the table depth; the value is below 16, so a few
  // compare-and-subtract steps are enough for any depth of two or more.
  function automatic logic [3:0] wrap_index(input logic [3:0] v);
    logic [8:0] r;
    r = {5'd0, v};
    for (int i = 0; i < 8; i++) begin
      if (r >= DEPTH_W9) begin
        r = r - DEPTH_W9;
      end
    end
    return r[3:0];
  endfunction

  function automatic logic [7:0] eff_duration(input macro_entry_t e);
    return (e.duration == 8'd0) ? 8'd1 : e.duration;
  endfunction

  // Configuration registers.
  logic [8:0] template_length;
  logic [7:0] fade_steps;

  // Sequencer state.
  seq_state_t   state, state_next;
  logic [8:0]   tick_count;
  logic [7:0]   repeat_count;
  logic [3:0]   entry_pointer;
  logic         prequel_flag;
  logic [15:0]  wave_step;
  logic [15:0]  wave_accum;
  logic [7:0]   dissolve_count;
  logic [7:0]   color_now;
  logic [7:0]   color_before;
  macro_entry_t act_word;
  logic         div_for_tick;
  logic [7:0]   ratio;

  // Start request fields held for the table read.
  logic [7:0]   st_delay;
  logic         st_has_color;
  logic [7:0]   st_color;

  // Shared serial divider.
  logic [7:0]   div_rem;
  logic [16:0]  div_num;
  logic [16:0]  div_quo;
  logic [7:0]   div_den;
  logic [4:0]   div_cnt;
  logic [8:0]   div_trial;
  logic         div_fit;
  logic [7:0]   div_rem_step;
  logic [16:0]  div_quo_step;
  logic         div_last;

  // Table memory.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  macro_entry_t  ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  macro_entry_t  rd_word;

  logic          accept;
  macro_entry_t  cur_word;
  logic          expire;
  logic [3:0]    next_ptr;
  logic [15:0]   ratio_prod;
  logic [7:0]    rev_index;

  assign accept    = start && !busy;
  assign rd_word   = macro_entry_t'(ram_rdata);
  assign cur_word  = prequel_flag ? PREQUEL_ENTRY : rd_word;
  assign expire    = (tick_count <= 9'd1);
  assign next_ptr  = wrap_index(cur_word.next);
  assign ratio_prod = {dissolve_count, 8'd0} - {8'd0, dissolve_count};
  assign rev_index = template_length[7:0] - 8'd1 - wave_accum[15:8];

  assign div_trial    = {div_rem, div_num[16]};
  assign div_fit      = (div_trial >= {1'b0, div_den});
  assign div_rem_step = div_fit ? 8'(div_trial - {1'b0, div_den}) : div_trial[7:0];
  assign div_quo_step = {div_quo[15:0], div_fit};
  assign div_last     = (div_cnt == 5'd1);

  assign ram_we = accept && (req_type == REQ_WRITE) && ({5'd0, entry_index} < DEPTH_W9);
  assign ram_waddr = AW'(entry_index);
  assign ram_wdata = '{
    color:     entry_color_id,
    has_color: entry_has_color,
    mode:      entry_mode,
    next:      entry_next,
    repeats:   entry_repeats,
    duration:  entry_duration
  };

  lems_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    ram_raddr  = AW'(entry_pointer);
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req_type)
            REQ_TICK:  state_next = S_TICK_RD;
            REQ_START: state_next = S_START_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_START_RD: begin
        ram_raddr  = '0;
        state_next = S_START_LOAD;
      end
      S_START_LOAD: state_next = S_WAVE_DIV;
      S_TICK_RD:    state_next = S_TICK_CUR;
      S_TICK_CUR: begin
        // The following entry is read here in case the current one runs out.
        ram_raddr = AW'(next_ptr);
        if (!expire) begin
          state_next = S_ADVANCE;
        end else if (repeat_count == 8'd0) begin
          state_next = S_TICK_NEW;
        end else begin
          state_next = S_WAVE_DIV;
        end
      end
      S_TICK_NEW: state_next = S_WAVE_DIV;
      S_WAVE_DIV: begin
        if (div_last) begin
          state_next = div_for_tick ? S_ADVANCE : S_IDLE;
        end
      end
      S_ADVANCE: state_next = S_RATIO_SETUP;
      S_RATIO_SETUP: begin
        if (fade_steps == 8'd0 || dissolve_count >= fade_steps) begin
          state_next = S_OUT;
        end else begin
          state_next = S_RATIO_DIV;
        end
      end
      S_RATIO_DIV: begin
        if (div_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      template_length <= 9'd256;
      fade_steps      <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TEMPLATE_LENGTH: template_length <= cfg_wdata;
        CFG_FADE_STEPS:      fade_steps      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count     <= '0;
      repeat_count   <= '0;
      entry_pointer  <= '0;
      prequel_flag   <= 1'b0;
      wave_step      <= '0;
      wave_accum     <= '0;
      dissolve_count <= '0;
      color_now      <= '0;
      color_before   <= '0;
      div_for_tick   <= 1'b0;
      div_cnt        <= '0;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept && req_type == REQ_START) begin
            st_delay     <= start_delay;
            st_has_color <= start_has_color;
            st_color     <= start_color_id;
          end
        end
        S_START_LOAD: begin
          color_now      <= st_has_color ? st_color : rd_word.color;
          color_before   <= st_has_color ? st_color : rd_word.color;
          entry_pointer  <= '0;
          prequel_flag   <= (st_delay != 8'd0);
          dissolve_count <= '0;
          if (st_delay != 8'd0) begin
            tick_count   <= {1'b0, st_delay} + 9'd1;
            repeat_count <= '0;
            act_word     <= PREQUEL_ENTRY;
            div_den      <= 8'd1;
          end else begin
            tick_count   <= {1'b0, eff_duration(rd_word)} + 9'd1;
            repeat_count <= rd_word.repeats;
            act_word     <= rd_word;
            div_den      <= eff_duration(rd_word);
          end
          div_rem      <= '0;
          div_num      <= {template_length, 8'd0};
          div_quo      <= '0;
          div_cnt      <= DIV_WAVE_STEPS;
          div_for_tick <= 1'b0;
        end
        S_TICK_CUR: begin
          if (!expire) begin
            tick_count <= tick_count - 9'd1;
            act_word   <= cur_word;
          end else if (repeat_count == 8'd0) begin
            entry_pointer <= next_ptr;
            prequel_flag  <= 1'b0;
          end else begin
            repeat_count <= repeat_count - 8'd1;
            act_word     <= cur_word;
            tick_count   <= {1'b0, eff_duration(cur_word)};
            div_rem      <= '0;
            div_num      <= {template_length, 8'd0};
            div_quo      <= '0;
            div_den      <= eff_duration(cur_word);
            div_cnt      <= DIV_WAVE_STEPS;
            div_for_tick <= 1'b1;
          end
        end
        S_TICK_NEW: begin
          repeat_count <= rd_word.repeats;
          if (rd_word.has_color) begin
            dissolve_count <= fade_steps;
            color_before   <= color_now;
            color_now      <= rd_word.color;
          end
          act_word     <= rd_word;
          tick_count   <= {1'b0, eff_duration(rd_word)};
          div_rem      <= '0;
          div_num      <= {template_length, 8'd0};
          div_quo      <= '0;
          div_den      <= eff_duration(rd_word);
          div_cnt      <= DIV_WAVE_STEPS;
          div_for_tick <= 1'b1;
        end
        S_WAVE_DIV: begin
          div_rem <= div_rem_step;
          div_num <= {div_num[15:0], 1'b0};
          div_quo <= div_quo_step;
          div_cnt <= div_cnt - 5'd1;
          if (div_last) begin
            // The accumulator restarts one step behind zero so the first tick lands on zero.
            wave_step  <= div_quo_step[15:0];
            wave_accum <= 16'd0 - div_quo_step[15:0];
          end
        end
        S_ADVANCE: begin
          wave_accum <= wave_accum + wave_step;
          if (dissolve_count != 8'd0) begin
            dissolve_count <= dissolve_count - 8'd1;
          end
        end
        S_RATIO_SETUP: begin
          if (fade_steps == 8'd0) begin
            ratio <= '0;
          end else if (dissolve_count >= fade_steps) begin
            ratio <= RATIO_FULL;
          end else begin
            // The quotient is known to fit in eight bits, so the high byte
            // of the dividend is already a valid partial remainder.
            div_rem <= ratio_prod[15:8];
            div_num <= {ratio_prod[7:0], 9'd0};
            div_quo <= '0;
            div_den <= fade_steps;
            div_cnt <= DIV_RATIO_STEPS;
          end
        end
        S_RATIO_DIV: begin
          div_rem <= div_rem_step;
          div_num <= {div_num[15:0], 1'b0};
          div_quo <= div_quo_step;
          div_cnt <= div_cnt - 5'd1;
          if (div_last) begin
            ratio <= div_quo_step[7:0];
          end
        end
        S_OUT: begin
          result_valid      <= 1'b1;
          mode              <= act_word.mode;
          active_entry      <= prequel_flag ? 4'd0 : entry_pointer;
          in_prequel        <= prequel_flag;
          sample_index      <= (act_word.mode == MODE_REVERSE_WAVE) ? rev_index
                                                                   : wave_accum[15:8];
          current_color_id  <= color_now;
          previous_color_id <= color_before;
          dissolve_ratio    <= ratio;
        end
        default: ;
      endcase
    end
  end

endmodule
